>>> sv/uds_tdc_pkg.sv
// ----------------------------------------------------------------------------
// uds_tdc_pkg
// Shared types and constants for the transfer-data checker and its channels.
// ----------------------------------------------------------------------------
package uds_tdc_pkg;

  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_DOWNLOAD_ACTIVE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DOWNLOAD_SIZE    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_BLOCK_LENGTH = 2'd2;

  localparam logic [7:0] COLON_CHAR       = 8'h3A;
  localparam logic [7:0] NIBBLE_MASK      = 8'h0F;
  localparam logic [7:0] MAX_LENGTH_RESET = 8'hFF;
  localparam logic [7:0] MIN_LENGTH       = 8'd3;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_POS   = 2'd1,
    KIND_NEG   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    NEG_SEQUENCE  = 2'd0,
    NEG_LENGTH    = 2'd1,
    NEG_SUSPENDED = 2'd2,
    NEG_COUNTER   = 2'd3
  } neg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] msg_length;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    kind_t      out_kind;
    logic [7:0] out_address;
    logic [7:0] out_value;
    neg_t       neg_code;
  } out_beat_t;

endpackage

>>> sv/uds_tdc_stream_if.sv
// ----------------------------------------------------------------------------
// uds_tdc_stream_if
// Valid/ready channel carrying one beat of a given payload type.
// ----------------------------------------------------------------------------
interface uds_tdc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> sv/uds_transfer_data_checker.sv
// ----------------------------------------------------------------------------
// uds_transfer_data_checker
// Byte-wise checker for transfer-data requests with decoded storage writes.
// ----------------------------------------------------------------------------
// Takes one request byte per cycle and gives at most one result per byte: a
// storage write for each decoded data pair, and a positive or negative
// response on the final byte. Each byte is checked and decoded in the cycle
// it is taken and the result lands in a single output register, so a new
// byte is taken every cycle while that register is empty or being drained.
// The user must write the registers through the plain write port only
// while no message is in flight; the block itself does not enforce this.
module uds_transfer_data_checker (
  input  logic                                       clk,
  input  logic                                       rst,
  uds_tdc_stream_if.sink                             in,
  uds_tdc_stream_if.source                           out,
  input  logic                                       cfg_write_en,
  input  logic [uds_tdc_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [uds_tdc_pkg::CFG_DATA_W-1:0]         cfg_data
);

  typedef enum logic [1:0] {
    MODE_CHECK = 2'd0,
    MODE_ECHO  = 2'd1,
    MODE_ERROR = 2'd2
  } mode_t;

  // configuration
  logic        download_active;
  logic [31:0] download_size;
  logic [7:0]  max_block_length;

  // transfer state
  logic [7:0]  expected_counter;
  logic [31:0] received_count;
  logic [7:0]  write_address;

  // per-message state
  logic [7:0]  byte_position;
  logic [7:0]  running_sum;
  logic [7:0]  high_nibble_byte;
  logic [7:0]  checksum_high;
  mode_t       message_mode;
  logic [7:0]  echo_counter;

  // output register
  logic                   res_valid;
  uds_tdc_pkg::out_beat_t res_beat;

  logic [7:0]  write_address_next;
  logic [7:0]  running_sum_next;
  logic [7:0]  high_nibble_byte_next;
  logic [7:0]  checksum_high_next;
  mode_t       message_mode_next;
  logic [7:0]  echo_counter_next;
  logic [7:0]  expected_counter_next;
  logic [31:0] received_count_next;

  logic                   beat_valid;
  uds_tdc_pkg::out_beat_t beat;

  logic                   accept;
  logic [7:0]             b;
  logic [7:0]             len;
  logic                   last;
  logic [8:0]             q9;
  logic [8:0]             len9;
  logic [31:0]            room;
  logic [7:0]             decoded;
  logic [7:0]             got;

  assign b      = in.payload.data_byte;
  assign len    = in.payload.msg_length;
  assign last   = in.payload.last_byte;
  assign q9     = {1'b0, byte_position};
  assign len9   = {1'b0, len};
  assign room   = download_size - received_count;
  assign accept = in.valid && in.ready;

  assign in.ready    = !res_valid || out.ready;
  assign out.valid   = res_valid;
  assign out.payload = res_beat;

  always_comb begin
    checksum_high_next    = (q9 + 9'd2 == len9) ? b : checksum_high;
    write_address_next    = write_address;
    running_sum_next      = running_sum;
    high_nibble_byte_next = high_nibble_byte;
    message_mode_next     = message_mode;
    echo_counter_next     = echo_counter;
    expected_counter_next = expected_counter;
    received_count_next   = received_count;
    decoded               = {high_nibble_byte[3:0], b[3:0]};
    got                   = {checksum_high_next[3:0], b[3:0]};
    beat_valid            = 1'b0;
    beat.out_kind         = uds_tdc_pkg::KIND_WRITE;
    beat.out_address      = 8'd0;
    beat.out_value        = 8'd0;
    beat.neg_code         = uds_tdc_pkg::NEG_SEQUENCE;

    if (byte_position == 8'd0) begin
      if (!download_active || download_size == received_count) begin
        message_mode_next = MODE_ERROR;
        echo_counter_next = {6'd0, uds_tdc_pkg::NEG_SEQUENCE};
      end else if (len < uds_tdc_pkg::MIN_LENGTH || len > max_block_length) begin
        message_mode_next = MODE_ERROR;
        echo_counter_next = {6'd0, uds_tdc_pkg::NEG_LENGTH};
      end
    end else if (message_mode == MODE_CHECK && byte_position < len) begin
      if (byte_position == 8'd1) begin
        if (b == expected_counter) begin
          if (room < {24'd0, len - 8'd2}) begin
            message_mode_next = MODE_ERROR;
            echo_counter_next = {6'd0, uds_tdc_pkg::NEG_SUSPENDED};
          end
        end else if (b == expected_counter - 8'd1) begin
          message_mode_next = MODE_ECHO;
          echo_counter_next = b;
        end else begin
          message_mode_next = MODE_ERROR;
          echo_counter_next = {6'd0, uds_tdc_pkg::NEG_COUNTER};
        end
      end else if (byte_position == 8'd2) begin
        if (b != uds_tdc_pkg::COLON_CHAR) begin
          message_mode_next = MODE_ERROR;
          echo_counter_next = {6'd0, uds_tdc_pkg::NEG_SUSPENDED};
        end
      end else if (byte_position[0] && (q9 + 9'd2 < len9)) begin
        if (b == uds_tdc_pkg::COLON_CHAR) begin
          message_mode_next = MODE_ERROR;
          echo_counter_next = {6'd0, uds_tdc_pkg::NEG_SUSPENDED};
        end else begin
          high_nibble_byte_next = b;
        end
      end else if (!byte_position[0] && (q9 + 9'd1 < len9)) begin
        if (b == uds_tdc_pkg::COLON_CHAR) begin
          message_mode_next = MODE_ERROR;
          echo_counter_next = {6'd0, uds_tdc_pkg::NEG_SUSPENDED};
        end else if (!last) begin
          beat_valid         = 1'b1;
          beat.out_address   = write_address;
          beat.out_value     = decoded;
          write_address_next = write_address + 8'd1;
          running_sum_next   = running_sum + decoded;
        end
      end
    end

    if (last) begin
      beat_valid       = 1'b1;
      beat.out_address = 8'd0;
      beat.out_value   = 8'd0;
      if (message_mode_next == MODE_ERROR) begin
        beat.out_kind = uds_tdc_pkg::KIND_NEG;
        beat.neg_code = uds_tdc_pkg::neg_t'(echo_counter_next[1:0]);
      end else if (q9 + 9'd1 != len9) begin
        beat.out_kind = uds_tdc_pkg::KIND_NEG;
        beat.neg_code = uds_tdc_pkg::NEG_LENGTH;
      end else if (message_mode_next == MODE_ECHO) begin
        beat.out_kind  = uds_tdc_pkg::KIND_POS;
        beat.out_value = echo_counter_next;
      end else if (got != 8'd0 - running_sum) begin
        beat.out_kind = uds_tdc_pkg::KIND_NEG;
        beat.neg_code = uds_tdc_pkg::NEG_SUSPENDED;
      end else begin
        beat.out_kind         = uds_tdc_pkg::KIND_POS;
        beat.out_value        = expected_counter;
        received_count_next   = received_count + {24'd0, len - 8'd2};
        expected_counter_next = expected_counter + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      download_active  <= 1'b0;
      download_size    <= 32'd0;
      max_block_length <= uds_tdc_pkg::MAX_LENGTH_RESET;
      expected_counter <= 8'd1;
      received_count   <= 32'd0;
      write_address    <= 8'd0;
      byte_position    <= 8'd0;
      running_sum      <= 8'd0;
      high_nibble_byte <= 8'd0;
      checksum_high    <= 8'd0;
      message_mode     <= MODE_CHECK;
      echo_counter     <= 8'd0;
      res_valid        <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          uds_tdc_pkg::REG_DOWNLOAD_ACTIVE:  download_active  <= cfg_data[0];
          uds_tdc_pkg::REG_DOWNLOAD_SIZE:    download_size    <= cfg_data;
          uds_tdc_pkg::REG_MAX_BLOCK_LENGTH: max_block_length <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (accept) begin
        expected_counter <= expected_counter_next;
        received_count   <= received_count_next;
        write_address    <= write_address_next;
        res_valid        <= beat_valid;
        if (last) begin
          byte_position    <= 8'd0;
          running_sum      <= 8'd0;
          high_nibble_byte <= 8'd0;
          checksum_high    <= 8'd0;
          message_mode     <= MODE_CHECK;
          echo_counter     <= 8'd0;
        end else begin
          if (byte_position != 8'hFF) begin
            byte_position <= byte_position + 8'd1;
          end
          running_sum      <= running_sum_next;
          high_nibble_byte <= high_nibble_byte_next;
          checksum_high    <= checksum_high_next;
          message_mode     <= message_mode_next;
          echo_counter     <= echo_counter_next;
        end
      end else if (out.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_beat <= beat;
    end
  end

endmodule

>>> bench/uds_tdc_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uds_tdc_result_checker
// Watches the request, response and register ports of the transfer-data
// checker, keeps its own model of the block's state, predicts every storage
// write and response, and compares each response beat field by field with
// the oldest prediction. Mismatches and unexpected beats are counted.
// ----------------------------------------------------------------------------
module uds_tdc_result_checker
  import uds_tdc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  input  logic                   req_ready,
  input  in_beat_t               req_beat,
  input  logic                   resp_valid,
  input  logic                   resp_ready,
  input  out_beat_t              resp_beat,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     failures,
  output int                     pending,
  output int                     writes_seen,
  output int                     positives_seen,
  output int                     negatives_seen
);

  typedef enum logic [1:0] {
    MODE_CHECK = 2'd0,
    MODE_ECHO  = 2'd1,
    MODE_ERROR = 2'd2
  } msg_mode_e;

  logic        cfg_active;
  logic [31:0] cfg_size;
  logic [7:0]  cfg_max;

  logic [7:0]  block_expected;
  logic [31:0] bytes_received;
  logic [7:0]  store_addr;
  logic [7:0]  byte_pos;
  logic [7:0]  data_sum;
  logic [7:0]  pair_high;
  logic [7:0]  sum_high;
  msg_mode_e   mode;
  logic [7:0]  echo_value;
  neg_t        held_code;

  out_beat_t   pending_results [$];

  task automatic set_error(input neg_t code);
    mode = MODE_ERROR;
    held_code = code;
  endtask

  task automatic end_of_message();
    byte_pos = 8'd0;
    data_sum = 8'd0;
    pair_high = 8'd0;
    sum_high = 8'd0;
    mode = MODE_CHECK;
    echo_value = 8'd0;
    held_code = NEG_SEQUENCE;
  endtask

  task automatic decode_request_byte(input in_beat_t beat, output logic has_res,
                                     output out_beat_t res);
    int          q;
    int          len;
    logic [7:0]  b;
    logic [7:0]  v;
    logic [7:0]  got;
    logic [31:0] room;
    b = beat.data_byte;
    len = int'(beat.msg_length);
    q = int'(byte_pos);
    has_res = 1'b0;
    res = '{out_kind: KIND_WRITE, out_address: 8'd0, out_value: 8'd0, neg_code: NEG_SEQUENCE};

    if (q == len - 2) sum_high = b;

    if (q == 0) begin
      if (!cfg_active || cfg_size == bytes_received) begin
        set_error(NEG_SEQUENCE);
      end else if (len < 3 || len > int'(cfg_max)) begin
        set_error(NEG_LENGTH);
      end
    end else if (mode == MODE_CHECK && q < len) begin
      if (q == 1) begin
        if (b == block_expected) begin
          room = cfg_size - bytes_received;
          if (room < 32'(len - 2)) set_error(NEG_SUSPENDED);
        end else if (b == block_expected - 8'd1) begin
          mode = MODE_ECHO;
          echo_value = b;
        end else begin
          set_error(NEG_COUNTER);
        end
      end else if (q == 2) begin
        if (b != COLON_CHAR) set_error(NEG_SUSPENDED);
      end else if (q[0] && q < len - 2) begin
        if (b == COLON_CHAR) set_error(NEG_SUSPENDED);
        else pair_high = b;
      end else if (!q[0] && q - 1 < len - 2) begin
        if (b == COLON_CHAR) begin
          set_error(NEG_SUSPENDED);
        end else if (!beat.last_byte) begin
          v = {pair_high[3:0], b[3:0]};
          res = '{out_kind: KIND_WRITE, out_address: store_addr, out_value: v,
                  neg_code: NEG_SEQUENCE};
          has_res = 1'b1;
          store_addr = store_addr + 8'd1;
          data_sum = data_sum + v;
        end
      end
    end

    if (byte_pos != 8'hFF) byte_pos = byte_pos + 8'd1;

    if (beat.last_byte) begin
      has_res = 1'b1;
      res = '{out_kind: KIND_NEG, out_address: 8'd0, out_value: 8'd0, neg_code: NEG_LENGTH};
      if (mode == MODE_ERROR) begin
        res.neg_code = held_code;
      end else if (q != len - 1) begin
        res.neg_code = NEG_LENGTH;
      end else if (mode == MODE_ECHO) begin
        res = '{out_kind: KIND_POS, out_address: 8'd0, out_value: echo_value,
                neg_code: NEG_SEQUENCE};
      end else begin
        got = {sum_high[3:0], b[3:0]};
        if (got != 8'd0 - data_sum) begin
          res.neg_code = NEG_SUSPENDED;
        end else begin
          res = '{out_kind: KIND_POS, out_address: 8'd0, out_value: block_expected,
                  neg_code: NEG_SEQUENCE};
          bytes_received = bytes_received + 32'(len - 2);
          block_expected = block_expected + 8'd1;
        end
      end
      end_of_message();
    end
  endtask

  // sample mid-cycle, the beat moves at the next rising edge
  always @(negedge clk) begin : watch
    out_beat_t want;
    out_beat_t res;
    logic      has_res;
    if (rst) begin
      cfg_active = 1'b0;
      cfg_size = 32'd0;
      cfg_max = MAX_LENGTH_RESET;
      block_expected = 8'd1;
      bytes_received = 32'd0;
      store_addr = 8'd0;
      end_of_message();
      pending_results.delete();
      failures = 0;
      writes_seen = 0;
      positives_seen = 0;
      negatives_seen = 0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_DOWNLOAD_ACTIVE: cfg_active = cfg_data[0];
          REG_DOWNLOAD_SIZE: cfg_size = cfg_data;
          REG_MAX_BLOCK_LENGTH: cfg_max = cfg_data[7:0];
          default: ;
        endcase
      end

      if (resp_valid && resp_ready) begin
        case (resp_beat.out_kind)
          KIND_WRITE: writes_seen++;
          KIND_POS: positives_seen++;
          default: negatives_seen++;
        endcase
        if (pending_results.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected beat: kind %0d addr 0x%02h value 0x%02h code %0d",
                     resp_beat.out_kind, resp_beat.out_address, resp_beat.out_value,
                     resp_beat.neg_code);
        end else begin
          want = pending_results.pop_front();
          if (resp_beat.out_kind !== want.out_kind ||
              resp_beat.out_address !== want.out_address ||
              resp_beat.out_value !== want.out_value ||
              resp_beat.neg_code !== want.neg_code) begin
            failures++;
            if (failures <= 10)
              $display({"mismatch: expected kind %0d addr 0x%02h value 0x%02h code %0d,",
                        " got kind %0d addr 0x%02h value 0x%02h code %0d"},
                       want.out_kind, want.out_address, want.out_value, want.neg_code,
                       resp_beat.out_kind, resp_beat.out_address, resp_beat.out_value,
                       resp_beat.neg_code);
          end
        end
      end

      if (req_valid && req_ready) begin
        decode_request_byte(req_beat, has_res, res);
        if (has_res) pending_results.push_back(res);
      end
    end
    pending = pending_results.size();
  end

endmodule

>>> bench/tb_uds_transfer_data_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uds_transfer_data_checker
// Sends transfer-data requests byte by byte through a series of register
// settings: a few hand-picked messages, then well-formed blocks with random
// payload mixed with broken and noisy ones. Both channels idle at random
// outside one steady stretch. A side checker predicts and compares every
// result beat; this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_uds_transfer_data_checker;
  import uds_tdc_pkg::*;

  localparam int CYCLE_LIMIT = 150000;

  typedef enum int {
    MSG_GOOD,
    MSG_ECHO,
    MSG_WRONG_COUNTER,
    MSG_NO_COLON,
    MSG_COLON_IN_DATA,
    MSG_BAD_SUM,
    MSG_EARLY_END,
    MSG_LATE_END,
    MSG_NOISE
  } msg_kind_e;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   result_ready = 1'b0;
  logic                   steady;

  int                     failures;
  int                     pending;
  int                     writes_seen;
  int                     positives_seen;
  int                     negatives_seen;

  int unsigned            cycles = 0;
  int unsigned            bytes_sent = 0;
  int unsigned            msgs_sent = 0;
  int unsigned            settings_used = 0;
  logic [7:0]             next_block = 8'd1;
  logic [31:0]            taken = 32'd0;
  logic                   cur_active = 1'b0;
  logic [31:0]            cur_size = 32'd0;
  logic [7:0]             cur_max = MAX_LENGTH_RESET;

  uds_tdc_stream_if #(.payload_t(in_beat_t))  req ();
  uds_tdc_stream_if #(.payload_t(out_beat_t)) resp ();

  assign resp.ready = result_ready;
  assign steady = (bytes_sent >= 300) && (bytes_sent < 380);

  uds_transfer_data_checker uut (
    .clk          (clk),
    .rst          (rst),
    .in           (req),
    .out          (resp),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  uds_tdc_result_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_beat       (req.payload),
    .resp_valid     (resp.valid),
    .resp_ready     (resp.ready),
    .resp_beat      (resp.payload),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .failures       (failures),
    .pending        (pending),
    .writes_seen    (writes_seen),
    .positives_seen (positives_seen),
    .negatives_seen (negatives_seen)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    result_ready <= steady || ($urandom_range(99) >= 22);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("uds_transfer_data_checker regression: fail");
      $finish;
    end
  end

  function automatic logic [7:0] rand_data();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == COLON_CHAR);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic [7:0] len, input logic last);
    in_beat_t beat;
    logic     acc;
    beat = '{data_byte: b, msg_length: len, last_byte: last};
    while (!steady && $urandom_range(99) < 22) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.payload <= beat;
    do begin
      @(negedge clk);
      acc = req.ready;
      @(posedge clk);
    end while (!acc);
    bytes_sent++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic setup(input logic active, input logic [31:0] size, input logic [7:0] max_len);
    drain();
    cfg_write_en <= 1'b1;
    cfg_index <= REG_DOWNLOAD_ACTIVE;
    cfg_data <= 32'(active);
    @(posedge clk);
    cfg_index <= REG_DOWNLOAD_SIZE;
    cfg_data <= size;
    @(posedge clk);
    cfg_index <= REG_MAX_BLOCK_LENGTH;
    cfg_data <= 32'(max_len);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cur_active = active;
    cur_size = size;
    cur_max = max_len;
    settings_used++;
  endtask

  // builds a valid block of the stated length (five bytes or more), then breaks it as asked
  task automatic send_message(input msg_kind_e kind, input int len);
    logic [7:0] msg [0:259];
    int         count;
    int         q;
    int         x;
    int         bound;
    logic [7:0] sum;
    logic [7:0] want;
    logic [7:0] hi;
    logic [7:0] lo;
    logic       found;
    logic       good;
    for (q = 0; q < 260; q++) msg[q] = rand_data();
    msg[1] = next_block;
    msg[2] = COLON_CHAR;
    sum = 8'd0;
    bound = (len % 2 == 0) ? len - 3 : len - 2;
    for (q = 3; q < bound; q += 2) sum = sum + {msg[q][3:0], msg[q + 1][3:0]};
    if (len >= 5 && len % 2 == 1) begin
      want = 8'd0 - sum;
      msg[len - 2] = {4'($urandom_range(15)), want[7:4]};
      msg[len - 1] = {4'($urandom_range(15)), want[3:0]};
    end else if (len >= 6) begin
      // the low byte of the last pair doubles as the checksum high half
      found = 1'b0;
      while (!found) begin
        hi = rand_data();
        for (x = 0; x < 16 && !found; x++) begin
          want = 8'd0 - (sum + {hi[3:0], 4'(x)});
          if (want[7:4] == 4'(x)) begin
            found = 1'b1;
            lo = {4'($urandom_range(15)), 4'(x)};
            if (lo == COLON_CHAR) lo[7:4] = 4'h7;
            msg[len - 3] = hi;
            msg[len - 2] = lo;
            msg[len - 1] = {4'($urandom_range(15)), want[3:0]};
          end
        end
      end
    end

    count = len;
    case (kind)
      MSG_ECHO: msg[1] = next_block - 8'd1;
      MSG_WRONG_COUNTER: begin
        do msg[1] = 8'($urandom_range(255));
        while (msg[1] == next_block || msg[1] == next_block - 8'd1);
      end
      MSG_NO_COLON: msg[2] = rand_data();
      MSG_COLON_IN_DATA: if (len >= 6) msg[$urandom_range(len - 3, 3)] = COLON_CHAR;
      MSG_BAD_SUM: if (len >= 1) msg[len - 1] = msg[len - 1] ^ 8'h01;
      MSG_EARLY_END: if (len > 1) count = $urandom_range(len - 1, 1);
      MSG_LATE_END: count = len + $urandom_range(4, 2);
      MSG_NOISE: begin
        for (q = 0; q < 260; q++) msg[q] = 8'($urandom_range(255));
        count = $urandom_range(((len + 2) < 16) ? len + 2 : 16, 1);
      end
      default: ;
    endcase
    if (count < 1) count = 1;

    // a five-byte block has no data pair to spoil, so it stays well formed
    good = (kind == MSG_GOOD || (kind == MSG_COLON_IN_DATA && len < 6)) &&
           len >= 5 && cur_active && cur_size != taken &&
           len <= int'(cur_max) && (cur_size - taken) >= 32'(len - 2);
    for (q = 0; q < count; q++) send_byte(msg[q], 8'(len), q == count - 1);
    if (good) begin
      taken = taken + 32'(len - 2);
      next_block = next_block + 8'd1;
    end
    msgs_sent++;
  endtask

  initial begin : stimulus
    int        phase_no;
    int        r;
    int        len;
    logic      long_done;
    msg_kind_e kind;
    req.valid = 1'b0;
    req.payload = '0;
    cfg_write_en = 1'b0;
    cfg_index = REG_DOWNLOAD_ACTIVE;
    cfg_data = '0;
    rst = 1'b1;
    long_done = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // no download accepted yet
    send_message(MSG_GOOD, 5);
    setup(1'b1, 32'hFFFF_FFFF, 8'd255);
    send_message(MSG_GOOD, 5);
    send_message(MSG_GOOD, 6);
    send_message(MSG_ECHO, 3);
    send_message(MSG_WRONG_COUNTER, 3);
    send_message(MSG_NO_COLON, 3);
    send_message(MSG_GOOD, 2);
    send_message(MSG_GOOD, 0);

    phase_no = 0;
    while (bytes_sent < 550) begin
      case (phase_no % 7)
        0: setup(1'b1, 32'hFFFF_FFFF, 8'd255);
        1: setup(1'b1, taken + 32'($urandom_range(60, 8)), 8'd255);
        2: setup(1'b1, 32'hFFFF_FFFF, MIN_LENGTH);
        3: setup(1'b0, 32'($urandom), 8'd255);
        4: setup(1'b1, 32'd0, 8'($urandom_range(40, 5)));
        5: setup(1'b1, taken, 8'd255);
        default: setup(1'b1, 32'hFFFF_FFFF, 8'($urandom_range(20, 5)));
      endcase
      if (phase_no % 7 == 0 && !long_done && bytes_sent > 100) begin
        // runs past 255 bytes so the position counter saturates
        send_message(MSG_LATE_END, 255);
        long_done = 1'b1;
      end
      repeat ($urandom_range(10, 4)) begin
        r = $urandom_range(99);
        if (r < 45) kind = MSG_GOOD;
        else if (r < 53) kind = MSG_ECHO;
        else if (r < 59) kind = MSG_WRONG_COUNTER;
        else if (r < 65) kind = MSG_NO_COLON;
        else if (r < 71) kind = MSG_COLON_IN_DATA;
        else if (r < 78) kind = MSG_BAD_SUM;
        else if (r < 84) kind = MSG_EARLY_END;
        else if (r < 90) kind = MSG_LATE_END;
        else kind = MSG_NOISE;
        if (kind == MSG_NOISE)
          len = ($urandom_range(2) == 0) ? $urandom_range(255) : $urandom_range(12);
        else if ($urandom_range(9) == 0)
          len = $urandom_range(40, 3);
        else
          len = $urandom_range(12, 5);
        send_message(kind, len);
      end
      phase_no++;
    end

    drain();
    repeat (10) @(posedge clk);
    $display("covered %0d request bytes in %0d messages over %0d register settings",
             bytes_sent, msgs_sent, settings_used);
    $display("checked %0d storage writes, %0d positive and %0d negative responses",
             writes_seen, positives_seen, negatives_seen);
    if (failures == 0) begin
      $display("uds_transfer_data_checker regression: pass");
    end else begin
      $display("uds_transfer_data_checker regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/uds_tdc_pkg.sv
sv/uds_tdc_stream_if.sv
sv/uds_transfer_data_checker.sv
bench/uds_tdc_result_checker.sv
bench/tb_uds_transfer_data_checker.sv
